// ===== src/prx_pkg.sv =====
// Shared constants and types for the printable run extractor.
`default_nettype none
package prx_pkg;

    localparam int MAX_RUN_DEF  = 1023;
    localparam int MAX_HOLD_DEF = 7;

    localparam int BYTE_W    = 8;
    localparam int MIN_LEN_W = 4;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 4'd4;

    localparam logic [BYTE_W-1:0] CHR_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_NL       = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_PRINT_HI = 8'h7E;

    // per-cell control: load from the input byte, or take the neighbor's byte
    typedef struct packed {
        logic wr;
        logic shift;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/prx_hold_cell.sv =====
// One cell of the held-head chain: stores one byte, loads or takes its neighbor's byte.
`default_nettype none
module prx_hold_cell (
    input  wire                           aclk,
    input  prx_pkg::cell_ctl_t            ctl,
    input  wire [prx_pkg::BYTE_W-1:0]     wr_data,
    input  wire [prx_pkg::BYTE_W-1:0]     shift_in,
    output logic [prx_pkg::BYTE_W-1:0]    q
);

    logic [prx_pkg::BYTE_W-1:0] byte_reg;
    logic [prx_pkg::BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.wr) begin
            byte_next = wr_data;
        end else if (ctl.shift) begin
            byte_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule
`default_nettype wire

// ===== src/printable_run_extractor.sv =====
// Top level of the printable run extractor: run tracking, held-head cell chain, output stage.
`default_nettype none
// Timing: an accepted beat's pass-through or terminator result is in the output register in the
// cycle after it is accepted. A head release (effective minimum m above 1) gives m results, one
// per cycle while the output is not stalled: m-1 from the rotating hold-cell chain, then the byte
// that completed it; drain_reg starts the release. Input is stalled until the release is over.
// Reset (aresetn low, synchronous): run length zero, min_length 4, output empty;
// the held bytes keep whatever they hold and are defined only once written.
module printable_run_extractor #(
    parameter int MAX_RUN  = prx_pkg::MAX_RUN_DEF,
    parameter int MAX_HOLD = prx_pkg::MAX_HOLD_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [7:0]                        s_tdata,   // [7:0] in_byte
    input  wire                              s_tlast,   // end_of_data

    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // run_end
    output logic                             m_tuser,   // [0] last_of_burst

    // configuration: min_length
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [prx_pkg::MIN_LEN_W-1:0]     cfg_data
);

    localparam int RLW = $clog2(MAX_RUN + 1);
    localparam int MW  = prx_pkg::MIN_LEN_W;
    localparam int BW  = prx_pkg::BYTE_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [RLW-1:0] run_len_reg,  run_len_next;
    logic [MW-1:0]  min_len_reg,  min_len_next;
    logic           drain_reg,    drain_next;   // head release in progress
    logic [MW-1:0]  rem_reg,      rem_next;     // held bytes still to release
    logic [BW-1:0]  cur_reg,      cur_next;     // byte that completed the minimum
    logic           out_vld_reg,  out_vld_next;
    logic [BW-1:0]  out_byte_reg, out_byte_next;
    logic           out_end_reg,  out_end_next;
    logic           out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Effective minimum: zero acts as one, clamp to hold depth + 1 and MAX_RUN
    // ------------------------------------------------------------------
    logic [MW-1:0] m_eff;

    always_comb begin
        m_eff = min_len_reg;
        if (m_eff == '0) begin
            m_eff = MW'(1);
        end
        if (int'(m_eff) > MAX_HOLD + 1) begin
            m_eff = MW'(MAX_HOLD + 1);
        end
        if (int'(m_eff) > MAX_RUN) begin
            m_eff = MW'(MAX_RUN);
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [BW-1:0]  in_byte;
    logic           in_eod;
    logic           in_fire;
    logic           out_free;
    logic           printable;
    logic           close_run;
    logic [RLW-1:0] rl_inc;
    logic [RLW-1:0] m_ext;
    logic           drain_step;

    assign in_byte   = s_tdata;
    assign in_eod    = s_tlast;
    assign out_free  = !out_vld_reg || m_tready;
    assign s_tready  = !drain_reg && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign printable = (in_byte >= prx_pkg::CHR_PRINT_LO) && (in_byte <= prx_pkg::CHR_PRINT_HI);
    // end of data, full run, NUL and newline all close the run
    assign close_run = in_eod || (int'(run_len_reg) >= MAX_RUN)
                       || (in_byte == prx_pkg::CHR_NUL) || (in_byte == prx_pkg::CHR_NL);
    assign rl_inc    = run_len_reg + RLW'(1);
    assign m_ext     = RLW'(m_eff);
    assign drain_step = drain_reg && out_free;

    // ------------------------------------------------------------------
    // Held-head cell chain. During a release the first m-1 cells rotate:
    // cell 0 goes out and comes back in at the far end, so the stored head
    // is intact once the release is over.
    // ------------------------------------------------------------------
    logic [BW-1:0]       cell_q  [MAX_HOLD];
    prx_pkg::cell_ctl_t  cell_ctl[MAX_HOLD];
    logic                rot;

    assign rot = drain_step && (rem_reg != '0);

    for (genvar i = 0; i < MAX_HOLD; i++) begin : g_cell
        logic [BW-1:0] src;

        if (i == MAX_HOLD - 1) begin : g_end
            assign src = cell_q[0];
        end else begin : g_mid
            assign src = ((i + 2) == int'(m_eff)) ? cell_q[0] : cell_q[i+1];
        end

        assign cell_ctl[i].wr    = in_fire && !close_run && printable
                                   && (rl_inc < m_ext) && (int'(rl_inc) == i + 1);
        assign cell_ctl[i].shift = rot && ((i + 1) < int'(m_eff));

        prx_hold_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[i]),
            .wr_data  (in_byte),
            .shift_in (src),
            .q        (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Run tracking and output stage
    // ------------------------------------------------------------------
    always_comb begin
        run_len_next  = run_len_reg;
        min_len_next  = min_len_reg;
        drain_next    = drain_reg;
        rem_next      = rem_reg;
        cur_next      = cur_reg;
        out_byte_next = out_byte_reg;
        out_end_next  = out_end_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !m_tready;

        if (cfg_valid && cfg_ready) begin
            min_len_next = cfg_data;
        end

        if (in_fire) begin
            if (close_run) begin
                // terminator only for a run that reached the minimum; drop short runs
                if (run_len_reg >= m_ext) begin
                    out_vld_next  = 1'b1;
                    out_byte_next = '0;
                    out_end_next  = 1'b1;
                    out_last_next = 1'b1;
                end
                run_len_next = '0;
            end else if (printable) begin
                run_len_next = rl_inc;
                if (rl_inc == m_ext) begin
                    if (m_eff == MW'(1)) begin
                        out_vld_next  = 1'b1;
                        out_byte_next = in_byte;
                        out_end_next  = 1'b0;
                        out_last_next = 1'b1;
                    end else begin
                        // release the head first, this byte after it
                        drain_next = 1'b1;
                        rem_next   = m_eff - MW'(1);
                        cur_next   = in_byte;
                    end
                end else if (rl_inc > m_ext) begin
                    out_vld_next  = 1'b1;
                    out_byte_next = in_byte;
                    out_end_next  = 1'b0;
                    out_last_next = 1'b1;
                end
            end
        end

        if (drain_step) begin
            out_vld_next = 1'b1;
            out_end_next = 1'b0;
            if (rem_reg != '0) begin
                out_byte_next = cell_q[0];
                out_last_next = 1'b0;
                rem_next      = rem_reg - MW'(1);
            end else begin
                out_byte_next = cur_reg;
                out_last_next = 1'b1;
                drain_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            min_len_reg <= prx_pkg::MIN_LEN_RESET;
            drain_reg   <= 1'b0;
            rem_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            run_len_reg <= run_len_next;
            min_len_reg <= min_len_next;
            drain_reg   <= drain_next;
            rem_reg     <= rem_next;
            out_vld_reg <= out_vld_next;
        end
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_last_reg;

endmodule
`default_nettype wire

// ===== test/tb_printable_run_extractor.sv =====
// Testbench for the printable run extractor: directed table and random runs.
`timescale 1ns / 1ps
module tb_printable_run_extractor;
    import prx_pkg::*;

    // The slowest correct run is about 500 beats, each worth at most eight results
    // behind random result-side stalls. Take that a few times over.
    localparam int LIMIT   = 1_000_000;
    localparam int MIN_CAP = MAX_HOLD_DEF + 1;
    // Quiet cycles before a min_length write: covers a head release still in progress.
    localparam int SETTLE  = MAX_HOLD_DEF + 3;

    typedef enum logic [1:0] {ROW_BYTE, ROW_EOD, ROW_MIN} row_kind_e;
    // What a directed beat must produce: ask the predictor, nothing, the byte itself
    // as a single pass-through result, or a single terminator.
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_CHAR, EXP_TERM} want_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [7:0]  value;
        want_e       want;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       run_end;
        logic       burst_last;
    } run_char_t;

    localparam int PLAN_ROWS = 29;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // no run open: a newline and an end-of-data beat give nothing
        '{ROW_BYTE, CHR_NL, EXP_NONE},
        '{ROW_EOD,  8'h41,  EXP_NONE},
        // minimum 8: seven bytes stay held and fill every head entry, then NUL
        // throws the short run away
        '{ROW_MIN,  8'd8,   EXP_NONE},
        '{ROW_BYTE, 8'h20,  EXP_NONE},
        '{ROW_BYTE, 8'h7E,  EXP_NONE},
        '{ROW_BYTE, 8'h61,  EXP_NONE},
        '{ROW_BYTE, 8'h5A,  EXP_NONE},
        '{ROW_BYTE, 8'h30,  EXP_NONE},
        '{ROW_BYTE, 8'h3F,  EXP_NONE},
        '{ROW_BYTE, 8'h25,  EXP_NONE},
        '{ROW_BYTE, CHR_NUL, EXP_NONE},
        // minimum 0 acts as 1: printable bytes pass at once, others are skipped
        '{ROW_MIN,  8'd0,   EXP_NONE},
        '{ROW_BYTE, 8'h41,  EXP_CHAR},
        '{ROW_BYTE, 8'h1F,  EXP_NONE},
        '{ROW_BYTE, 8'h7F,  EXP_NONE},
        '{ROW_BYTE, 8'hFF,  EXP_NONE},
        '{ROW_BYTE, 8'h7E,  EXP_CHAR},
        '{ROW_BYTE, CHR_NL, EXP_TERM},
        // minimum 15 acts as 8: a skipped control byte inside the run, release on
        // the eighth printable byte, end of data closes the run
        '{ROW_MIN,  8'd15,  EXP_NONE},
        '{ROW_BYTE, 8'h48,  EXP_NONE},
        '{ROW_BYTE, 8'h65,  EXP_NONE},
        '{ROW_BYTE, 8'h01,  EXP_NONE},
        '{ROW_BYTE, 8'h6C,  EXP_NONE},
        '{ROW_BYTE, 8'h6C,  EXP_NONE},
        '{ROW_BYTE, 8'h6F,  EXP_NONE},
        '{ROW_BYTE, 8'h20,  EXP_NONE},
        '{ROW_BYTE, 8'h77,  EXP_NONE},
        '{ROW_BYTE, 8'h21,  EXP_MODEL},
        '{ROW_EOD,  8'h00,  EXP_TERM}
    };

    localparam logic [MIN_LEN_W-1:0] MIN_EXTREMES [4] = '{4'd1, 4'd8, 4'd15, 4'd0};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    logic                 m_tready  = 1'b0;
    wire [7:0]            m_tdata;
    wire                  m_tlast;
    wire                  m_tuser;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [MIN_LEN_W-1:0] cfg_data  = '0;

    // travels beside s_tdata so the checker sees it at the same edge as the beat
    want_e beat_want = EXP_MODEL;

    // predictor state
    logic [7:0]           head_bytes [MAX_HOLD_DEF];
    int                   run_len = 0;
    logic [MIN_LEN_W-1:0] min_len = MIN_LEN_RESET;

    run_char_t step_chars [$];   // results of the beat just accepted
    run_char_t owed_chars [$];   // results the block still has to deliver

    logic send_gaps   = 1'b0;
    logic sink_stalls = 1'b0;
    int   n_errors     = 0;
    int   n_checked    = 0;
    int   n_beats      = 0;
    int   n_min_writes = 0;
    int   cycles       = 0;

    printable_run_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Advance the run by one input beat and collect what it releases in step_chars.
    function automatic void strings_step(input logic [7:0] b, input logic eod);
        int m;
        int i;
        step_chars.delete();
        m = (min_len == 0) ? 1 : int'(min_len);
        if (m > MIN_CAP) m = MIN_CAP;
        if (eod || run_len >= MAX_RUN_DEF || b == CHR_NUL || b == CHR_NL) begin
            // close the run; only a run that reached the minimum gets a terminator
            if (run_len >= m) step_chars.push_back('{CHR_NUL, 1'b1, 1'b0});
            run_len = 0;
        end else if (b >= CHR_PRINT_LO && b <= CHR_PRINT_HI) begin
            run_len++;
            if (run_len < m) begin
                head_bytes[run_len - 1] = b;
            end else if (run_len == m) begin
                // release the held head in order, then the byte that completed it
                for (i = 0; i < m - 1; i++) step_chars.push_back('{head_bytes[i], 1'b0, 1'b0});
                step_chars.push_back('{b, 1'b0, 1'b0});
            end else begin
                step_chars.push_back('{b, 1'b0, 1'b0});
            end
        end
        if (step_chars.size() != 0) step_chars[step_chars.size() - 1].burst_last = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input run_char_t got, input run_char_t want);
        n_errors++;
        $display("%0t %s: got byte %h end %b last %b, want byte %h end %b last %b",
                 $realtime, what, got.chr, got.run_end, got.burst_last,
                 want.chr, want.run_end, want.burst_last);
    endtask

    // Predict on every accepted input beat and check every accepted result beat.
    // Both live in one block so a push and a pop never race each other.
    always @(posedge aclk) begin
        run_char_t got;
        run_char_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) min_len = cfg_data;
            if (s_tvalid && s_tready) begin
                strings_step(s_tdata, s_tlast);
                // directed rows with an obvious answer override the predictor's list
                case (beat_want)
                    EXP_NONE: begin
                        step_chars.delete();
                    end
                    EXP_CHAR: begin
                        step_chars.delete();
                        step_chars.push_back('{s_tdata, 1'b0, 1'b1});
                    end
                    EXP_TERM: begin
                        step_chars.delete();
                        step_chars.push_back('{CHR_NUL, 1'b1, 1'b1});
                    end
                    default: ;
                endcase
                foreach (step_chars[i]) owed_chars.push_back(step_chars[i]);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast, m_tuser};
                n_checked++;
                if (owed_chars.size() == 0) begin
                    flag_mismatch("result with nothing owed", got, '0);
                end else begin
                    want = owed_chars.pop_front();
                    if (got.chr !== want.chr || got.run_end !== want.run_end ||
                        got.burst_last !== want.burst_last) begin
                        flag_mismatch("result mismatch", got, want);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     owed_chars.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: hold tready low in random bursts while stalls are enabled.
    initial begin
        wait (aresetn);
        forever begin
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Offer one input beat and hold it until accepted, then maybe drop valid for a burst.
    task automatic send_beat(input logic [7:0] b, input logic eod, input want_e want);
        s_tdata   <= b;
        s_tlast   <= eod;
        s_tvalid  <= 1'b1;
        beat_want <= want;
        do @(posedge aclk); while (!s_tready);
        n_beats++;
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every owed result is out, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_chars.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_min(input logic [MIN_LEN_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_min_writes++;
    endtask

    // A control byte that neither prints nor ends a run.
    function automatic logic [7:0] skip_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CHR_PRINT_LO && b <= CHR_PRINT_HI) || b == CHR_NUL || b == CHR_NL);
        return b;
    endfunction

    // Mostly well-formed runs of random length and content, some noise and stray ends.
    // Only printable bytes and run ends count toward the quota.
    task automatic send_random(input int quota);
        int         counted;
        int         len;
        int         k;
        int         pick;
        logic [7:0] b;
        logic       eod;
        counted = 0;
        while (counted < quota) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // short runs mostly, some past the largest head to exercise pass-through
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0) send_beat(skip_byte(), 1'b0, EXP_MODEL);
                    send_beat(8'($urandom_range(32, 126)), 1'b0, EXP_MODEL);
                end
                case ($urandom_range(0, 2))
                    0:       send_beat(CHR_NUL, 1'b0, EXP_MODEL);
                    1:       send_beat(CHR_NL, 1'b0, EXP_MODEL);
                    default: send_beat(8'($urandom_range(0, 255)), 1'b1, EXP_MODEL);
                endcase
                counted += len + 1;
            end else if (pick < 9) begin
                b   = 8'($urandom_range(0, 255));
                eod = ($urandom_range(0, 15) == 0);
                send_beat(b, eod, EXP_MODEL);
                if (eod || b == CHR_NUL || b == CHR_NL || (b >= CHR_PRINT_LO && b <= CHR_PRINT_HI))
                    counted++;
            end else begin
                // stray end of data, often with no run open
                send_beat(8'($urandom_range(0, 255)), 1'b1, EXP_MODEL);
                counted++;
            end
        end
    endtask

    initial begin
        int i;
        int ph;
        logic [MIN_LEN_W-1:0] v;

        // hold reset once, at the start
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table. The first block of rows writes every head entry before
        // anything can be released, so later minimum changes never read a blank entry.
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
        for (i = 0; i < PLAN_ROWS; i++) begin
            case (PLAN[i].kind)
                ROW_MIN: begin
                    drain_results();
                    write_min(PLAN[i].value[MIN_LEN_W-1:0]);
                end
                ROW_EOD: begin
                    send_beat(PLAN[i].value, 1'b1, EXP_MODEL == PLAN[i].want ?
                              EXP_MODEL : PLAN[i].want);
                end
                default: begin
                    send_beat(PLAN[i].value, 1'b0, PLAN[i].want);
                end
            endcase
        end

        // Random phases. Each starts with a full pause until every result is out,
        // then a new minimum; runs left open carry across the write on purpose.
        for (ph = 0; ph < 8; ph++) begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            v = (ph < 4) ? MIN_EXTREMES[ph] : MIN_LEN_W'($urandom_range(0, 15));
            drain_results();
            write_min(v);
            send_random(38);
        end

        // Last stretch at full rate on both sides, closed by end of data.
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        send_random(40);
        send_beat(8'($urandom_range(0, 255)), 1'b1, EXP_MODEL);
        drain_results();

        $display("run covered %0d input beats over %0d min_length settings, stalls on both sides",
                 n_beats, n_min_writes);
        $display("checked %0d result beats, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/prx_pkg.sv
src/prx_hold_cell.sv
src/printable_run_extractor.sv
test/tb_printable_run_extractor.sv
